>>> design/rgbwa_pkg.sv
// ----------------------------------------------------------------------------
// rgbwa_pkg
// Shared constants and types of the moving-average color classifier.
// ----------------------------------------------------------------------------
package rgbwa_pkg;

  localparam int unsigned WINDOW_SAMPLES_DEF = 8;
  localparam int unsigned NUM_COLORS_DEF     = 6;

  localparam int unsigned CHAN_W   = 16;
  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned REF_W    = NUM_CHAN * CHAN_W;
  localparam int unsigned REF_REGS = 6;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned PADDR_W  = 6;
  localparam int unsigned PDATA_W  = 64;

  typedef enum logic [2:0] {
    CFG_REF_0,
    CFG_REF_1,
    CFG_REF_2,
    CFG_REF_3,
    CFG_REF_4,
    CFG_REF_5,
    CFG_TOL
  } cfg_reg_e;

  typedef struct packed {
    logic s1_load;
    logic s2_load;
  } pipe_ctrl_t;

endpackage

>>> design/rgb_window_average_color_match.sv
// ----------------------------------------------------------------------------
// rgb_window_average_color_match
// Moving-average color classifier over a window of sensor samples.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel carries one red, green and blue sample. It
// is taken when in_valid_i is high and in_stall_o is low. Each request gives
// one result: the three window averages after this sample, the index of the
// first reference color whose every channel lies strictly inside reference
// plus or minus tolerance, and a no-match flag.
// A request passes the reciprocal-multiply register, the running-sum update
// and the output register, which takes the parallel color compares and the
// priority merge, before out_valid_o rises. Throughput is one request per
// cycle unless out_stall_i backs up the pipeline, set by the running-sum
// update that each request makes on the one before it.
// Reset clears the sample window, the sums and all configuration registers.
// When out_stall_i holds a result, the stages behind it keep filling; only
// when all three are full does in_stall_o rise.
// Configuration goes through the APB port at byte address 8*i; the user must
// write it only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module rgb_window_average_color_match
  import rgbwa_pkg::*;
#(
  parameter int unsigned WindowSamples = WINDOW_SAMPLES_DEF,
  parameter int unsigned NumColors     = NUM_COLORS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CHAN_W-1:0]  red_sample_i,
  input  logic [CHAN_W-1:0]  green_sample_i,
  input  logic [CHAN_W-1:0]  blue_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CHAN_W-1:0]  red_average_o,
  output logic [CHAN_W-1:0]  green_average_o,
  output logic [CHAN_W-1:0]  blue_average_o,
  output logic [IDX_W-1:0]   color_index_o,
  output logic               no_match_o
);

  logic [REF_W-1:0]  ref_q [REF_REGS];
  logic [CHAN_W-1:0] tol_q;
  cfg_reg_e          cfg_idx;
  logic              cfg_wr;

  assign cfg_idx = cfg_reg_e'(paddr[PADDR_W-1:PADDR_W-IDX_W]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
      for (int k = 0; k < REF_REGS; k++) begin
        ref_q[k] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_idx == CFG_TOL) begin
        tol_q <= pwdata[CHAN_W-1:0];
      end
      for (int k = 0; k < REF_REGS; k++) begin
        if (cfg_idx == cfg_reg_e'(k)) begin
          ref_q[k] <= pwdata[REF_W-1:0];
        end
      end
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_REF_0: prdata = PDATA_W'(ref_q[0]);
      CFG_REF_1: prdata = PDATA_W'(ref_q[1]);
      CFG_REF_2: prdata = PDATA_W'(ref_q[2]);
      CFG_REF_3: prdata = PDATA_W'(ref_q[3]);
      CFG_REF_4: prdata = PDATA_W'(ref_q[4]);
      CFG_REF_5: prdata = PDATA_W'(ref_q[5]);
      CFG_TOL:   prdata = PDATA_W'(tol_q);
      default:   prdata = '0;
    endcase
  end

  logic       v1_q, v2_q, out_valid_q;
  logic       out_ready, s2_ready, s1_ready, out_load;
  pipe_ctrl_t ctrl;

  assign out_ready    = !out_valid_q || !out_stall_i;
  assign s2_ready     = !v2_q || out_ready;
  assign s1_ready     = !v1_q || s2_ready;
  assign ctrl.s1_load = in_valid_i && s1_ready;
  assign ctrl.s2_load = v1_q && s2_ready;
  assign out_load     = v2_q && out_ready;
  assign in_stall_o   = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= ctrl.s1_load || (v1_q && !s2_ready);
      v2_q        <= ctrl.s2_load || (v2_q && !out_ready);
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  logic [NUM_CHAN-1:0][CHAN_W-1:0] sample;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] sum;

  assign sample = {red_sample_i, green_sample_i, blue_sample_i};

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    rgbwa_chan_avg #(
      .WindowSamples(WindowSamples)
    ) u_chan_avg (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sample_i(sample[c]),
      .sum_o   (sum[c])
    );
  end

  logic [NumColors-1:0] match;

  for (genvar k = 0; k < NumColors; k++) begin : g_lane
    rgbwa_color_lane u_color_lane (
      .avg_i  (sum),
      .ref_i  (ref_q[k]),
      .tol_i  (tol_q),
      .match_o(match[k])
    );
  end

  logic [IDX_W-1:0] idx_d;
  logic             miss_d;

  rgbwa_merge #(
    .NumColors(NumColors)
  ) u_merge (
    .match_i      (match),
    .color_index_o(idx_d),
    .no_match_o   (miss_d)
  );

  logic [NUM_CHAN-1:0][CHAN_W-1:0] avg_q;
  logic [IDX_W-1:0]                idx_q;
  logic                            miss_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_q  <= sum;
      idx_q  <= idx_d;
      miss_q <= miss_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_average_o   = avg_q[2];
  assign green_average_o = avg_q[1];
  assign blue_average_o  = avg_q[0];
  assign color_index_o   = idx_q;
  assign no_match_o      = miss_q;

endmodule

>>> design/rgbwa_chan_avg.sv
// ----------------------------------------------------------------------------
// rgbwa_chan_avg
// One channel: divides each sample by the window length, keeps the last
// window of quotients in a shift line and maintains their running sum.
// ----------------------------------------------------------------------------
module rgbwa_chan_avg
  import rgbwa_pkg::*;
#(
  parameter int unsigned WindowSamples = WINDOW_SAMPLES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pipe_ctrl_t        ctrl_i,
  input  logic [CHAN_W-1:0] sample_i,
  output logic [CHAN_W-1:0] sum_o
);

  localparam int unsigned DivShift = CHAN_W + $clog2(WindowSamples);
  localparam logic [CHAN_W:0] DivMult = (CHAN_W + 1)'(
      ((64'd1 << DivShift) + 64'(WindowSamples) - 64'd1) / 64'(WindowSamples));
  localparam int unsigned QuotMax = ((1 << CHAN_W) - 1) / WindowSamples;
  localparam int unsigned QuotW   = $clog2(QuotMax + 1);
  localparam int unsigned ProdW   = 2 * CHAN_W + 1;

  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot_d, quot_q;
  logic [QuotW-1:0]  line_q [WindowSamples];
  logic [CHAN_W-1:0] sum_d, sum_q;

  assign prod   = ProdW'(sample_i) * ProdW'(DivMult);
  assign quot_d = QuotW'(prod >> DivShift);
  assign sum_d  = sum_q + CHAN_W'(quot_q) - CHAN_W'(line_q[WindowSamples-1]);
  assign sum_o  = sum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1_load) begin
      quot_q <= quot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int i = 0; i < WindowSamples; i++) begin
        line_q[i] <= '0;
      end
    end else if (ctrl_i.s2_load) begin
      sum_q     <= sum_d;
      line_q[0] <= quot_q;
      for (int i = 1; i < WindowSamples; i++) begin
        line_q[i] <= line_q[i-1];
      end
    end
  end

endmodule

>>> design/rgbwa_color_lane.sv
// ----------------------------------------------------------------------------
// rgbwa_color_lane
// Tests the three averages against one reference color and its strict
// tolerance window.
// ----------------------------------------------------------------------------
module rgbwa_color_lane
  import rgbwa_pkg::*;
(
  input  logic [NUM_CHAN-1:0][CHAN_W-1:0] avg_i,
  input  logic [NUM_CHAN-1:0][CHAN_W-1:0] ref_i,
  input  logic [CHAN_W-1:0]               tol_i,
  output logic                            match_o
);

  logic [NUM_CHAN-1:0] in_band;

  // The window test ref - tol < avg < ref + tol is rewritten without
  // subtraction so that all terms stay unsigned.
  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      in_band[c] = ((CHAN_W + 1)'(ref_i[c]) < (CHAN_W + 1)'(avg_i[c]) + (CHAN_W + 1)'(tol_i))
                && ((CHAN_W + 1)'(avg_i[c]) < (CHAN_W + 1)'(ref_i[c]) + (CHAN_W + 1)'(tol_i));
    end
  end

  assign match_o = &in_band;

endmodule

>>> design/rgbwa_merge.sv
// ----------------------------------------------------------------------------
// rgbwa_merge
// Picks the lowest-numbered matching color lane.
// ----------------------------------------------------------------------------
module rgbwa_merge
  import rgbwa_pkg::*;
#(
  parameter int unsigned NumColors = NUM_COLORS_DEF
) (
  input  logic [NumColors-1:0] match_i,
  output logic [IDX_W-1:0]     color_index_o,
  output logic                 no_match_o
);

  always_comb begin
    color_index_o = '0;
    for (int k = NumColors - 1; k >= 0; k--) begin
      if (match_i[k]) begin
        color_index_o = IDX_W'(k);
      end
    end
  end

  assign no_match_o = ~|match_i;

endmodule

>>> design/rgbwa_checker.sv
// ----------------------------------------------------------------------------
// rgbwa_checker
// Port-level checks of the color classifier, bound to the top level.
// ----------------------------------------------------------------------------
module rgbwa_checker
  import rgbwa_pkg::*;
#(
  parameter int unsigned NumColors = NUM_COLORS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              pready,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CHAN_W-1:0] red_average_o,
  input logic [CHAN_W-1:0] green_average_o,
  input logic [CHAN_W-1:0] blue_average_o,
  input logic [IDX_W-1:0]  color_index_o,
  input logic              no_match_o
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the output side can move");

  a_no_match_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_match_o) |-> (color_index_o == '0))
    else $error("nonzero color index with no match");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !no_match_o) |-> (color_index_o < IDX_W'(NumColors)))
    else $error("color index beyond the compared colors");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(red_average_o)
      && $stable(green_average_o) && $stable(blue_average_o)
      && $stable(color_index_o) && $stable(no_match_o)))
    else $error("stalled result changed");

endmodule

bind rgb_window_average_color_match rgbwa_checker #(
  .NumColors(NumColors)
) u_rgbwa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .pready         (pready),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .red_average_o  (red_average_o),
  .green_average_o(green_average_o),
  .blue_average_o (blue_average_o),
  .color_index_o  (color_index_o),
  .no_match_o     (no_match_o)
);

>>> verif/tb_rgb_window_average_color_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_window_average_color_match
// Self-checking testbench for the moving-average color classifier.
// A queue of sensor samples feeds a bursty driver, and a predictor keeps its
// own window, running sums and register copies to compute each result. A
// monitor compares every accepted result field by field with the oldest
// prediction while the receiver stalls on a changing pattern. Phases of
// directed and random samples run under several reference and tolerance
// settings, written over APB while the block is idle.
// ----------------------------------------------------------------------------
module tb_rgb_window_average_color_match;
  import rgbwa_pkg::*;

  localparam int unsigned CFG_UNMAPPED   = 7;
  localparam int unsigned IDLE_SETTLE    = 6;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 7;
  localparam int unsigned PHASE_SAMPLES  = 150;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_avg;
    logic [CHAN_W-1:0] green_avg;
    logic [CHAN_W-1:0] blue_avg;
    logic [IDX_W-1:0]  color_index;
    logic              no_match;
  } match_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [CHAN_W-1:0]  red_sample_i;
  logic [CHAN_W-1:0]  green_sample_i;
  logic [CHAN_W-1:0]  blue_sample_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [CHAN_W-1:0]  red_average_o;
  logic [CHAN_W-1:0]  green_average_o;
  logic [CHAN_W-1:0]  blue_average_o;
  logic [IDX_W-1:0]   color_index_o;
  logic               no_match_o;

  rgb_t          sample_queue[$];
  match_result_t expected_matches[$];

  rgb_t              window_model[WINDOW_SAMPLES_DEF];
  int unsigned       window_pos;
  logic [CHAN_W-1:0] sum_red;
  logic [CHAN_W-1:0] sum_green;
  logic [CHAN_W-1:0] sum_blue;
  rgb_t              ref_colors[REF_REGS];
  logic [CHAN_W-1:0] tol_model;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_mode;
  int unsigned stall_seg_left;
  int unsigned quiet_cycles;
  int unsigned fail_count;

  rgb_window_average_color_match u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .red_sample_i   (red_sample_i),
    .green_sample_i (green_sample_i),
    .blue_sample_i  (blue_sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_average_o  (red_average_o),
    .green_average_o(green_average_o),
    .blue_average_o (blue_average_o),
    .color_index_o  (color_index_o),
    .no_match_o     (no_match_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit within_band(logic [CHAN_W-1:0] avg, logic [CHAN_W-1:0] ref_ch);
    int a;
    int r;
    int t;
    a = int'(avg);
    r = int'(ref_ch);
    t = int'(tol_model);
    return (r - t < a) && (a < r + t);
  endfunction

  function automatic match_result_t predict_color_match(rgb_t smp);
    match_result_t res;
    rgb_t          old_smp;
    window_pos = (window_pos + 1) % WINDOW_SAMPLES_DEF;
    old_smp = window_model[window_pos];
    sum_red   = CHAN_W'(sum_red - old_smp.red / WINDOW_SAMPLES_DEF
                        + smp.red / WINDOW_SAMPLES_DEF);
    sum_green = CHAN_W'(sum_green - old_smp.green / WINDOW_SAMPLES_DEF
                        + smp.green / WINDOW_SAMPLES_DEF);
    sum_blue  = CHAN_W'(sum_blue - old_smp.blue / WINDOW_SAMPLES_DEF
                        + smp.blue / WINDOW_SAMPLES_DEF);
    window_model[window_pos] = smp;
    res.red_avg     = sum_red;
    res.green_avg   = sum_green;
    res.blue_avg    = sum_blue;
    res.color_index = '0;
    res.no_match    = 1'b1;
    for (int k = 0; k < NUM_COLORS_DEF && k < REF_REGS; k++) begin
      if (res.no_match && within_band(sum_red, ref_colors[k].red) &&
          within_band(sum_green, ref_colors[k].green) &&
          within_band(sum_blue, ref_colors[k].blue)) begin
        res.color_index = IDX_W'(k);
        res.no_match    = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic void push_sample(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                      logic [CHAN_W-1:0] b);
    sample_queue.push_back(rgb_t'({r, g, b}));
  endfunction

  function automatic logic [CHAN_W-1:0] jitter_sample(logic [CHAN_W-1:0] center,
                                                      int unsigned spread);
    int v;
    v = int'(center) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return CHAN_W'(v);
  endfunction

  task automatic apb_write(int unsigned reg_idx, logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(reg_idx * 8);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_idx < REF_REGS) begin
      ref_colors[reg_idx] = rgb_t'(data[REF_W-1:0]);
    end else if (reg_idx == CFG_TOL) begin
      tol_model = data[CHAN_W-1:0];
    end
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (sample_queue.size() != 0 || in_valid_i || expected_matches.size() != 0);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic check_field(string field, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Driver: bursts of requests separated by random gaps.
  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      expected_matches.push_back(
        predict_color_match(rgb_t'({red_sample_i, green_sample_i, blue_sample_i})));
    end
    if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        rgb_t nxt;
        nxt = sample_queue.pop_front();
        red_sample_i   <= nxt.red;
        green_sample_i <= nxt.green;
        blue_sample_i  <= nxt.blue;
        in_valid_i     <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: segments of free flow, light, heavy and toggling stall.
  always @(posedge clk_i) begin
    if (stall_seg_left == 0) begin
      stall_mode     = $urandom_range(0, 3);
      stall_seg_left = $urandom_range(4, 60);
    end else begin
      stall_seg_left--;
    end
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall_i <= ~out_stall_i;
      end
    endcase
  end

  // Monitor.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result: no request outstanding");
        fail_count++;
      end else begin
        match_result_t exp_res;
        exp_res = expected_matches.pop_front();
        check_field("red_average", exp_res.red_avg, red_average_o);
        check_field("green_average", exp_res.green_avg, green_average_o);
        check_field("blue_average", exp_res.blue_avg, blue_average_o);
        check_field("color_index", exp_res.color_index, color_index_o);
        check_field("no_match", exp_res.no_match, no_match_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned       run_len;
    int unsigned       mode;
    int unsigned       pick;
    int unsigned       spread;
    int unsigned       items;
    logic [REF_W-1:0]  refv;
    logic [CHAN_W-1:0] tolv;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    red_sample_i   = '0;
    green_sample_i = '0;
    blue_sample_i  = '0;
    out_stall_i    = 1'b0;
    window_pos     = 0;
    sum_red        = '0;
    sum_green      = '0;
    sum_blue       = '0;
    tol_model      = '0;
    burst_left     = 0;
    gap_left       = 0;
    stall_mode     = 0;
    stall_seg_left = 0;
    quiet_cycles   = 0;
    fail_count     = 0;
    for (int i = 0; i < WINDOW_SAMPLES_DEF; i++) window_model[i] = '0;
    for (int i = 0; i < REF_REGS; i++) ref_colors[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: zero tolerance, so nothing can match.
    for (int i = 0; i < WINDOW_SAMPLES_DEF; i++) push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(16'hFFFF, 16'h0000, 16'h0000);
    push_sample(16'h0000, 16'hFFFF, 16'h0000);
    push_sample(16'h0000, 16'h0000, 16'hFFFF);
    push_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    push_sample(16'd7, 16'd8, 16'd15);
    for (int i = 0; i < 6; i++) push_sample(16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // Extreme settings: full tolerance, first reference at full scale.
    apb_write(CFG_REF_0, {16'hDEAD, 48'hFFFF_FFFF_FFFF});
    for (int k = 1; k < REF_REGS; k++) apb_write(int'(CFG_REF_0) + k, {16'hBEEF, 48'h0});
    apb_write(CFG_TOL, {48'hFFFF_FFFF_FFFF, 16'hFFFF});
    apb_write(CFG_UNMAPPED, {$urandom, $urandom});
    for (int i = 0; i < 3; i++) push_sample(16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 4; i++) push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_idle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int k = 0; k < REF_REGS; k++) begin
        case ($urandom_range(0, 4))
          0: begin
            refv = {($urandom_range(0, 1) ? 16'hFFFF : 16'h0000),
                    ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000),
                    ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000)};
          end
          1: begin
            refv = (k > 0) ? REF_W'(ref_colors[k-1]) : REF_W'({$urandom, $urandom});
          end
          default: begin
            refv = REF_W'({$urandom, $urandom});
          end
        endcase
        apb_write(int'(CFG_REF_0) + k, {16'($urandom), refv});
      end
      case ((ph == 0) ? 3 : $urandom_range(0, 4))
        0:       tolv = '0;
        1:       tolv = CHAN_W'($urandom_range(1, 16));
        2:       tolv = CHAN_W'($urandom_range(17, 4096));
        3:       tolv = 16'hFFFF;
        default: tolv = CHAN_W'($urandom_range(0, 65535));
      endcase
      apb_write(CFG_TOL, {48'({$urandom, $urandom}), tolv});
      if ($urandom_range(0, 1)) apb_write(CFG_UNMAPPED, {$urandom, $urandom});

      items = 0;
      while (items < PHASE_SAMPLES) begin
        run_len = $urandom_range(8, 20);
        mode    = $urandom_range(0, 9);
        pick    = $urandom_range(0, REF_REGS - 1);
        spread  = $urandom_range(0, tolv / 2 + 8);
        for (int i = 0; i < run_len; i++) begin
          if (mode < 8) begin
            push_sample(jitter_sample(ref_colors[pick].red, spread),
                        jitter_sample(ref_colors[pick].green, spread),
                        jitter_sample(ref_colors[pick].blue, spread));
          end else if (mode == 8) begin
            push_sample(16'($urandom), 16'($urandom), 16'($urandom));
          end else begin
            push_sample(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                        16'($urandom_range(0, 15)));
          end
        end
        items += run_len;
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
design/rgbwa_pkg.sv
design/rgbwa_chan_avg.sv
design/rgbwa_color_lane.sv
design/rgbwa_merge.sv
design/rgb_window_average_color_match.sv
design/rgbwa_checker.sv
verif/tb_rgb_window_average_color_match.sv
